>>> hw/rtl/pattern_dedup_table_top_defines.svh
// Assertion macros for the checker file of the pattern table.
`ifndef PATTERN_DEDUP_TABLE_TOP_DEFINES_SVH
`define PATTERN_DEDUP_TABLE_TOP_DEFINES_SVH

// A condition that must hold in the same cycle as its trigger.
`define PDT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pattern_dedup_table: same-cycle check failed");

// A condition that must hold in the cycle after its trigger.
`define PDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pattern_dedup_table: next-cycle check failed");

`endif

>>> hw/rtl/pdt_pkg.sv
package pdt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int PIXEL_BITS  = 8;
	localparam int COUNT_BITS  = 16;
	localparam int WIN_SIDE    = 3;
	localparam int WIN_CELLS   = WIN_SIDE * WIN_SIDE;
	localparam int WIN_W       = WIN_CELLS * PIXEL_BITS;

	localparam int FIELD_PIX_W = 8;
	localparam int IN_DATA_W   = WIN_CELLS * FIELD_PIX_W;

	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
	localparam int CAP_W       = 9;
	localparam int CMP_W       = (USED_W > CAP_W) ? USED_W : CAP_W;
	localparam int CAP_RESET   = 256;

	localparam int OUT_IDX_W   = 8;
	localparam int OUT_FREQ_W  = 16;
	localparam int OUT_DATA_W  = OUT_IDX_W + OUT_FREQ_W;
	localparam int OUT_USER_W  = 2;

	typedef struct packed {
		logic                  active;
		logic                  hit;
		logic                  is_new;
		logic [IDX_W-1:0]      idx;
		logic [COUNT_BITS-1:0] freq;
	} tok_t;

endpackage

>>> hw/rtl/pdt_cell.sv
module pdt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [pdt_pkg::IDX_W-1:0]  cell_idx,
	input  logic [pdt_pkg::WIN_W-1:0]  win,
	input  logic [pdt_pkg::USED_W-1:0] used,
	input  logic                      room,
	input  pdt_pkg::tok_t             tok_in,
	output pdt_pkg::tok_t             tok_out
);
	import pdt_pkg::*;

	logic [WIN_W-1:0]      pat_q;
	logic [COUNT_BITS-1:0] cnt_q;
	tok_t                  tok_q;

	logic                  filled;
	logic                  at_end;
	logic                  match;
	logic                  append;
	logic [COUNT_BITS-1:0] cnt_inc;
	tok_t                  tok_d;

	assign filled  = USED_W'(cell_idx) < used;
	assign at_end  = USED_W'(cell_idx) == used;
	assign match   = tok_in.active && !tok_in.hit && filled && (pat_q == win);
	assign append  = tok_in.active && !tok_in.hit && at_end && room;
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);

	always_comb begin
		tok_d = tok_in;
		if (match) begin
			tok_d.hit  = 1'b1;
			tok_d.idx  = cell_idx;
			tok_d.freq = cnt_inc;
		end else if (append) begin
			tok_d.hit    = 1'b1;
			tok_d.is_new = 1'b1;
			tok_d.idx    = cell_idx;
			tok_d.freq   = COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			cnt_q <= cnt_inc;
		end else if (append) begin
			pat_q <= win;
			cnt_q <= COUNT_BITS'(1);
		end
	end

	assign tok_out = tok_q;

endmodule

>>> hw/rtl/pattern_dedup_table_top.sv
// Channel  Direction  Payload
// s_*      in         tdata: 3x3 window, nine 8-bit pixels
// m_*      out        tdata: pattern_index, frequency; tuser: is_new, overflow
// cfg_*    in         capacity_limit, 9 bits
//
// One window at a time walks a row of TABLE_DEPTH cells, one cell a cycle.
// A new window is not taken before the last one has left the cell row and
// its result has moved on from the pending register into the output register.
// The pattern and count stores need no clearing pass after reset.
// A result waiting on m_tready can stop the next window from entering.
module pattern_dedup_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pix_r0_c0, pix_r0_c1, pix_r0_c2, pix_r1_c0 .. pix_r2_c2
	input  logic [pdt_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pattern_index, frequency
	output logic [pdt_pkg::OUT_DATA_W-1:0] m_tdata,
	// is_new, overflow
	output logic [pdt_pkg::OUT_USER_W-1:0] m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pdt_pkg::CAP_W-1:0]      cfg_data
);
	import pdt_pkg::*;

	logic                  busy_q;
	logic                  start_q;
	logic [WIN_W-1:0]      win_q;
	logic [USED_W-1:0]     used_q;
	logic [CAP_W-1:0]      cap_q;
	logic                  pend_valid_q;
	tok_t                  pend_q;
	logic                  m_valid_q;
	logic [OUT_IDX_W-1:0]  m_idx_q;
	logic [OUT_FREQ_W-1:0] m_freq_q;
	logic                  m_new_q;
	logic                  m_ovf_q;

	logic                  s_accept;
	logic                  pend_move;
	logic                  room;
	logic [CMP_W-1:0]      limit;
	logic [WIN_W-1:0]      win_d;
	tok_t                  chain [TABLE_DEPTH+1];
	tok_t                  exit_tok;

	assign s_tready  = !busy_q && !pend_valid_q;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign pend_move = pend_valid_q && (!m_valid_q || m_tready);

	assign limit = (CMP_W'(cap_q) < CMP_W'(TABLE_DEPTH)) ? CMP_W'(cap_q) : CMP_W'(TABLE_DEPTH);
	assign room  = CMP_W'(used_q) < limit;

	always_comb begin
		for (int k = 0; k < WIN_CELLS; k++) begin
			win_d[k*PIXEL_BITS +: PIXEL_BITS] = s_tdata[k*FIELD_PIX_W +: PIXEL_BITS];
		end
	end

	always_comb begin
		chain[0]        = '0;
		chain[0].active = start_q;
	end

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		pdt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(k)),
			.win      (win_q),
			.used     (used_q),
			.room     (room),
			.tok_in   (chain[k]),
			.tok_out  (chain[k+1])
		);
	end

	assign exit_tok = chain[TABLE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			start_q      <= 1'b0;
			used_q       <= '0;
			cap_q        <= CAP_W'(CAP_RESET);
			pend_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			start_q <= s_accept;
			if (s_accept) begin
				busy_q <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (exit_tok.active) begin
				busy_q       <= 1'b0;
				pend_valid_q <= 1'b1;
				if (exit_tok.is_new) begin
					used_q <= used_q + USED_W'(1);
				end
			end else if (pend_move) begin
				pend_valid_q <= 1'b0;
			end
			if (pend_move) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			win_q <= win_d;
		end
		if (exit_tok.active) begin
			pend_q <= exit_tok;
		end
		if (pend_move) begin
			m_idx_q  <= OUT_IDX_W'(pend_q.idx);
			m_freq_q <= OUT_FREQ_W'(pend_q.freq);
			m_new_q  <= pend_q.is_new;
			m_ovf_q  <= !pend_q.hit;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_freq_q, m_idx_q};
	assign m_tuser  = {m_ovf_q, m_new_q};

endmodule

>>> hw/rtl/pdt_checker.sv
`include "pattern_dedup_table_top_defines.svh"

module pdt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pdt_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [pdt_pkg::OUT_USER_W-1:0] m_tuser
);
	import pdt_pkg::*;

	// A stalled result word keeps its contents.
	`PDT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Only one window is in the cell row at a time.
	`PDT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// An overflow word carries neither an index nor a count.
	`PDT_ASSERT_SAME(a_ovf_zero, clk, arst_n, m_tvalid && m_tuser[1], m_tdata == '0 && !m_tuser[0])

	// A freshly stored pattern has been seen exactly once.
	`PDT_ASSERT_SAME(a_new_once, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[OUT_DATA_W-1:OUT_IDX_W] == OUT_FREQ_W'(1))

endmodule

bind pattern_dedup_table_top pdt_checker u_pdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

	typedef logic [pdt_pkg::IN_DATA_W-1:0] window_t;

	typedef struct packed {
		logic                          overflow;
		logic                          is_new;
		logic [pdt_pkg::OUT_FREQ_W-1:0] freq;
		logic [pdt_pkg::OUT_IDX_W-1:0]  pat_index;
	} dedup_result_t;

	// Keeps its own copy of the pattern table and predicts the reply to each window.
	class pattern_table_check;
		window_t                       stored [pdt_pkg::TABLE_DEPTH];
		logic [pdt_pkg::COUNT_BITS-1:0] uses [pdt_pkg::TABLE_DEPTH];
		int unsigned                   filled;
		logic [pdt_pkg::CAP_W-1:0]     capacity;
		dedup_result_t                 awaited_results [$];
		int unsigned                   mismatches;

		function new();
			filled = 0;
			capacity = pdt_pkg::CAP_W'(pdt_pkg::CAP_RESET);
			mismatches = 0;
		endfunction

		function void set_capacity(logic [pdt_pkg::CAP_W-1:0] value);
			capacity = value;
		endfunction

		function void note_window(window_t win);
			int unsigned limit;
			dedup_result_t r;
			bit hit;
			limit = (capacity < pdt_pkg::TABLE_DEPTH) ? capacity : pdt_pkg::TABLE_DEPTH;
			r = '0;
			hit = 0;
			for (int k = 0; k < filled; k++) begin
				if (!hit && stored[k] == win) begin
					hit = 1;
					if (uses[k] != {pdt_pkg::COUNT_BITS{1'b1}})
						uses[k] = uses[k] + 1'b1;
					r.pat_index = k[pdt_pkg::OUT_IDX_W-1:0];
					r.freq = uses[k][pdt_pkg::OUT_FREQ_W-1:0];
				end
			end
			if (!hit) begin
				if (filled >= limit) begin
					r.overflow = 1'b1;
				end else begin
					stored[filled] = win;
					uses[filled] = pdt_pkg::COUNT_BITS'(1);
					r.pat_index = filled[pdt_pkg::OUT_IDX_W-1:0];
					r.is_new = 1'b1;
					r.freq = pdt_pkg::OUT_FREQ_W'(1);
					filled++;
				end
			end
			awaited_results = {awaited_results, r};
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_result(dedup_result_t got);
			dedup_result_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("result word with no window outstanding: %h", got));
			end else begin
				want = awaited_results.pop_front();
				if (got.pat_index != want.pat_index)
					report($sformatf("pattern_index %0d, expected %0d", got.pat_index,
						want.pat_index));
				if (got.is_new != want.is_new)
					report($sformatf("is_new %0b, expected %0b", got.is_new, want.is_new));
				if (got.freq != want.freq)
					report($sformatf("frequency %0d, expected %0d", got.freq, want.freq));
				if (got.overflow != want.overflow)
					report($sformatf("overflow %0b, expected %0b", got.overflow,
						want.overflow));
			end
		endtask
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [pdt_pkg::IN_DATA_W-1:0]     s_tdata = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [pdt_pkg::OUT_DATA_W-1:0]    m_tdata;
	logic [pdt_pkg::OUT_USER_W-1:0]    m_tuser;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [pdt_pkg::CAP_W-1:0]         cfg_data = '0;

	pattern_table_check table_check;

	pattern_dedup_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 4);
		else if (r < 98)
			return $urandom_range(5, 30);
		return $urandom_range(100, 300);
	endfunction

	function automatic window_t pick_window(int new_pct);
		window_t w;
		int mode;
		if (table_check.filled == 0 || $urandom_range(0, 99) < new_pct) begin
			mode = (table_check.filled == 0) ? $urandom_range(0, 1) : $urandom_range(0, 2);
			w = '0;
			for (int k = 0; k < pdt_pkg::WIN_CELLS; k++) begin
				case (mode)
					0: w[8*k +: 8] = 8'($urandom_range(0, 255));
					1: begin
						case ($urandom_range(0, 2))
							0: w[8*k +: 8] = 8'h00;
							1: w[8*k +: 8] = 8'hFF;
							default: w[8*k +: 8] = 8'($urandom_range(0, 255));
						endcase
					end
					default: ;
				endcase
			end
			// A near miss: a stored pattern with one bit turned over.
			if (mode == 2) begin
				w = table_check.stored[$urandom_range(0, table_check.filled - 1)];
				w[$urandom_range(0, pdt_pkg::IN_DATA_W - 1)] ^= 1'b1;
			end
		end else begin
			w = table_check.stored[$urandom_range(0, table_check.filled - 1)];
		end
		return w;
	endfunction

	// Valid stays high from one word into the next when no gap is wanted.
	task send_window(window_t win, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= win;
		do @(posedge clk); while (!s_tready);
		table_check.note_window(win);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (table_check.awaited_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task write_capacity(logic [pdt_pkg::CAP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		table_check.set_capacity(value);
	endtask

	task run_random(int count, int new_pct);
		for (int i = 0; i < count; i++)
			send_window(pick_window(new_pct), pick_gap());
	endtask

	initial begin
		int stall;
		dedup_result_t got;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.pat_index = m_tdata[pdt_pkg::OUT_IDX_W-1:0];
				got.freq = m_tdata[pdt_pkg::OUT_IDX_W +: pdt_pkg::OUT_FREQ_W];
				got.is_new = m_tuser[0];
				got.overflow = m_tuser[1];
				table_check.check_result(got);
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		window_t w;
		table_check = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_window('0, pick_gap());
		send_window('1, pick_gap());
		send_window('0, pick_gap());
		send_window('1, pick_gap());
		for (int k = 0; k < pdt_pkg::WIN_CELLS; k++) begin
			w = '0;
			w[8*k +: 8] = 8'h80;
			send_window(w, pick_gap());
		end
		w = '0;
		w[pdt_pkg::IN_DATA_W-8 +: 8] = 8'h01;
		send_window(w, pick_gap());
		send_window({9{8'hAA}}, pick_gap());
		send_window({9{8'h55}}, pick_gap());
		send_window({9{8'hAA}}, pick_gap());
		send_window({8'h00, {4{16'hFF00}}}, pick_gap());
		w = '0;
		w[8*4 +: 8] = 8'h80;
		send_window(w, pick_gap());

		// No room at all, then a limit below the entries already held.
		drain();
		write_capacity(9'd0);
		run_random(40, 40);
		drain();
		write_capacity(9'd1);
		run_random(40, 40);
		drain();
		write_capacity(9'd100);
		run_random(300, 50);
		// A limit above the table depth lets the table fill to the end.
		drain();
		write_capacity(9'd511);
		run_random(400, 45);
		drain();
		write_capacity(9'd256);
		run_random(400, 25);
		drain();
		repeat (300) @(posedge clk);

		if (table_check.mismatches == 0)
			$display("** pattern_dedup_table_top: PASSED **");
		else
			$display("** pattern_dedup_table_top: FAILED **");
		$finish;
	end

	initial begin
		#50000000;
		$display("** pattern_dedup_table_top: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pdt_pkg.sv
hw/rtl/pdt_cell.sv
hw/rtl/pattern_dedup_table_top.sv
hw/rtl/pdt_checker.sv
dv/tb.sv
